>>> sv/fastcgi_record_deframer_defines.svh
// Assertion macros used by the checker file of the FastCGI record deframer.
// No dependencies; included by bare file name.
`ifndef FASTCGI_RECORD_DEFRAMER_DEFINES_SVH
`define FASTCGI_RECORD_DEFRAMER_DEFINES_SVH

// Antecedent implies consequent in the same cycle, disabled during reset.
`define FCGI_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the following cycle, disabled during reset.
`define FCGI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/fcgi_pkg.sv
// Shared types and constants of the FastCGI record deframer.
// No dependencies; imported by the parser, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package fcgi_pkg;

  // Record header geometry.
  localparam int unsigned HDR_BYTES = 8;
  localparam int unsigned HDR_IDX_W = $clog2(HDR_BYTES);
  localparam logic [HDR_IDX_W-1:0] HDR_IDX_TYPE  = HDR_IDX_W'(1);
  localparam logic [HDR_IDX_W-1:0] HDR_IDX_LEN_H = HDR_IDX_W'(4);
  localparam logic [HDR_IDX_W-1:0] HDR_IDX_LEN_L = HDR_IDX_W'(5);
  localparam logic [HDR_IDX_W-1:0] HDR_IDX_PAD   = HDR_IDX_W'(6);
  localparam logic [HDR_IDX_W-1:0] HDR_IDX_LAST  = HDR_IDX_W'(HDR_BYTES - 1);

  // Record types handled.
  localparam logic [7:0] TYPE_END_REQUEST = 8'd3;
  localparam logic [7:0] TYPE_STDOUT      = 8'd6;
  localparam logic [7:0] TYPE_STDERR      = 8'd7;

  // Event codes carried on the result channel.
  typedef enum logic [2:0] {
    EV_STDOUT     = 3'd0,
    EV_STDERR     = 3'd1,
    EV_REQ_END    = 3'd2,
    EV_STDOUT_END = 3'd3,
    EV_BAD_TYPE   = 3'd4
  } event_kind_t;

  // One result from the parser.
  typedef struct packed {
    logic        valid;
    event_kind_t kind;
    logic [7:0]  data;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

>>> sv/fastcgi_record_deframer.sv
// Top level of the FastCGI record deframer: input register, parser, result register.
// Depends on fcgi_pkg and fcgi_parser.
//
//   Channel | Direction | Request contents
//   --------+-----------+------------------------------------------------------
//   in_     | slave     | one byte of the application's reply stream
//   out_    | master    | event kind, content byte, last-content-byte flag
//
// One byte is taken per cycle while no result is stalled; each byte waits in the input
// register until its step is committed, and its result, if any, is then registered in the output register.
// Throughput is set by the parser step, a single counter update per byte.
// Reset is synchronous and active low; it clears the parser and both valid flags.
// A stalled result holds the input register; one further byte is held there.
`timescale 1ns / 1ps
`default_nettype none

module fastcgi_record_deframer
  import fcgi_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,    // [7:0] stream_byte
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,   // [7:0] payload_byte
  output logic [2:0]      out_tuser,   // [2:0] event_kind
  output logic            out_tlast    // record_last
);

  logic       in_valid_r;
  logic [7:0] in_data_r;
  logic       step_en;
  result_t    result;

  logic       out_valid_r;
  logic [7:0] out_data_r;
  logic [2:0] out_kind_r;
  logic       out_last_r;

  // The held byte is stepped whenever the result register can take its outcome.
  assign step_en   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step_en;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r <= in_tdata;
    end
  end

  fcgi_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .byte_in (in_data_r),
    .result  (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en) begin
      out_valid_r <= result.valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && result.valid) begin
      out_data_r <= result.data;
      out_kind_r <= result.kind;
      out_last_r <= result.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

>>> sv/fcgi_parser.sv
// Record parser state and its one-byte step for the FastCGI record deframer.
// Depends on fcgi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcgi_parser
  import fcgi_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step_en,   // commit the step for byte_in
  input  wire logic [7:0] byte_in,
  output result_t         result     // result of the step, valid with step_en
);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_CONTENT = 2'd1,
    PH_PADDING = 2'd2
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [HDR_IDX_W-1:0]   hdr_idx_r, hdr_idx_nxt;
  logic [7:0]             rec_type_r, rec_type_nxt;
  logic [7:0]             len_high_r, len_high_nxt;
  logic [15:0]            content_left_r, content_left_nxt;
  logic [7:0]             pad_left_r, pad_left_nxt;
  logic                   halted_r, halted_nxt;

  logic [15:0]            content_dec;
  logic [7:0]             pad_dec;
  logic                   type_ok;

  assign content_dec = content_left_r - 16'd1;
  assign pad_dec     = pad_left_r - 8'd1;
  assign type_ok     = (rec_type_r == TYPE_STDOUT) || (rec_type_r == TYPE_STDERR) ||
                       (rec_type_r == TYPE_END_REQUEST);

  // Next state and result for one received byte.
  always_comb begin
    phase_nxt        = phase_r;
    hdr_idx_nxt      = hdr_idx_r;
    rec_type_nxt     = rec_type_r;
    len_high_nxt     = len_high_r;
    content_left_nxt = content_left_r;
    pad_left_nxt     = pad_left_r;
    halted_nxt       = halted_r;
    result           = '0;
    result.kind      = EV_STDOUT;

    if (!halted_r) begin
      case (phase_r)
        PH_CONTENT: begin
          content_left_nxt = content_dec;
          if (content_dec == 16'd0) begin
            phase_nxt   = (pad_left_r != 8'd0) ? PH_PADDING : PH_HEADER;
            hdr_idx_nxt = '0;
          end
          if (rec_type_r == TYPE_STDOUT) begin
            result.valid = 1'b1;
            result.kind  = EV_STDOUT;
            result.data  = byte_in;
            result.last  = (content_dec == 16'd0);
          end else if (rec_type_r == TYPE_STDERR) begin
            result.valid = 1'b1;
            result.kind  = EV_STDERR;
            result.data  = byte_in;
            result.last  = (content_dec == 16'd0);
          end else if (content_dec == 16'd0) begin
            // Last byte of the end-request body.
            halted_nxt   = 1'b1;
            result.valid = 1'b1;
            result.kind  = EV_REQ_END;
            result.last  = 1'b1;
          end
        end
        PH_PADDING: begin
          pad_left_nxt = pad_dec;
          if (pad_dec == 8'd0) begin
            phase_nxt   = PH_HEADER;
            hdr_idx_nxt = '0;
          end
        end
        default: begin
          // Header phase; the unused phase code is treated the same way.
          phase_nxt = PH_HEADER;
          case (hdr_idx_r)
            HDR_IDX_TYPE:  rec_type_nxt     = byte_in;
            HDR_IDX_LEN_H: len_high_nxt     = byte_in;
            HDR_IDX_LEN_L: content_left_nxt = {len_high_r, byte_in};
            HDR_IDX_PAD:   pad_left_nxt     = byte_in;
            default:       ;
          endcase
          if (hdr_idx_r != HDR_IDX_LAST) begin
            hdr_idx_nxt = hdr_idx_r + HDR_IDX_W'(1);
          end else begin
            // The header is judged on its last byte.
            hdr_idx_nxt = '0;
            if (!type_ok) begin
              halted_nxt   = 1'b1;
              result.valid = 1'b1;
              result.kind  = EV_BAD_TYPE;
            end else if (content_left_r != 16'd0) begin
              phase_nxt = PH_CONTENT;
            end else begin
              phase_nxt = (pad_left_r != 8'd0) ? PH_PADDING : PH_HEADER;
              if (rec_type_r == TYPE_STDOUT) begin
                result.valid = 1'b1;
                result.kind  = EV_STDOUT_END;
              end else if (rec_type_r == TYPE_END_REQUEST) begin
                halted_nxt   = 1'b1;
                result.valid = 1'b1;
                result.kind  = EV_REQ_END;
              end
            end
          end
        end
      endcase
    end
  end

  // Parser state registers, updated only when the step is committed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HEADER;
      hdr_idx_r      <= '0;
      rec_type_r     <= '0;
      len_high_r     <= '0;
      content_left_r <= '0;
      pad_left_r     <= '0;
      halted_r       <= 1'b0;
    end else if (step_en) begin
      phase_r        <= phase_nxt;
      hdr_idx_r      <= hdr_idx_nxt;
      rec_type_r     <= rec_type_nxt;
      len_high_r     <= len_high_nxt;
      content_left_r <= content_left_nxt;
      pad_left_r     <= pad_left_nxt;
      halted_r       <= halted_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/fcgi_checker.sv
// Port-level checks of the FastCGI record deframer, bound to its top level.
// Depends on fcgi_pkg and fastcgi_record_deframer_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "fastcgi_record_deframer_defines.svh"

module fcgi_checker
  import fcgi_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic [7:0] in_tdata,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic [2:0] out_tuser,
  input wire logic       out_tlast
);

  logic is_data;
  logic out_take;
  logic halt_take;
  logic in_stall;
  logic out_stall;
  logic hdr_event;

  assign is_data   = (out_tuser == EV_STDOUT) || (out_tuser == EV_STDERR);
  assign out_take  = out_tvalid && out_tready;
  assign halt_take = out_take && ((out_tuser == EV_BAD_TYPE) || (out_tuser == EV_REQ_END));
  assign in_stall  = in_tvalid && !in_tready;
  assign out_stall = out_tvalid && !out_tready;
  assign hdr_event = out_tvalid && ((out_tuser == EV_STDOUT_END) || (out_tuser == EV_BAD_TYPE));

  // A waiting input request stays offered with the same byte.
  `FCGI_ASSERT_NEXT(a_in_hold, clk, rst_n, in_stall,
                    in_tvalid && $stable(in_tdata), "input request changed while waiting")

  // A stalled result keeps its contents.
  `FCGI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall,
                    out_tvalid && $stable(out_tdata) && $stable(out_tuser)
                    && $stable(out_tlast), "result changed while stalled")

  // Only data events carry a content byte.
  `FCGI_ASSERT_SAME(a_zero_payload, clk, rst_n, out_tvalid && !is_data,
                    out_tdata == 8'd0, "non-data event with a payload byte")

  // End-of-stream and bad-type events never mark a last content byte.
  `FCGI_ASSERT_SAME(a_no_last, clk, rst_n, hdr_event, !out_tlast, "last flag on a header event")

  // Once a halting event is taken, nothing follows it.
  `FCGI_ASSERT_NEXT(a_halt_quiet, clk, rst_n, halt_take, !out_tvalid,
                    "result after a halting event")

endmodule

bind fastcgi_record_deframer fcgi_checker u_fcgi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
